@@ src/clqm_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular linked queue manager package
// Sizes, field widths and the request and status codes used by the queue
// manager and its link memories.
// ----------------------------------------------------------------------------
package clqm_pkg;

   // Pool of element handles and number of queues that share it.
   localparam int POOL_SIZE  = 64;
   localparam int NUM_QUEUES = 8;

   // Field widths of the request and response items.
   localparam int FUNC_W     = 2;
   localparam int QUEUE_W    = 3;
   localparam int ELEM_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [QUEUE_W-1:0]  queue_type;
   typedef logic [ELEM_W-1:0]   elem_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

   // Request function codes. Every other code reports the queue size; the
   // spare code behaves exactly like the size report.
   localparam func_type FUNC_APPEND = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_SIZE   = 2'd2;
   localparam func_type FUNC_SPARE  = 2'd3;

   // Response status codes.
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_LINKED = 2'd1;
   localparam status_type STATUS_EMPTY  = 2'd2;
   localparam status_type STATUS_ABSENT = 2'd3;

endpackage

@@ src/clqm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read. A read at the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module clqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/circular_linked_queue_manager.sv @@
// ----------------------------------------------------------------------------
// Circular linked queue manager
// Keeps a pool of element handles linked into several circular doubly
// linked queues and serves append, remove and size requests.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel carries a function (append,
// remove or report size), a queue index and an element handle. Every
// request produces exactly one response on the rsp_ channel with a status,
// the removed handle (zero unless a remove succeeded) and the element count
// of the addressed queue after the operation.
// A request is first registered while its element's link and owner
// memories are read; the decode stage then decides the operation, writes
// the memories and loads the response register.
// Throughput is one request per cycle while rsp_tready stays high; the
// one-write-port link memories set this figure, and the design keeps
// each operation to a single write per memory by holding the tail of
// every queue in a register.
// Reset empties every queue and unlinks every element; the link memories
// are not cleared, since they are read only for linked elements.
// When the receiver holds rsp_tready low, the response register keeps its
// item, one more request can still be taken into the decode stage, and
// then req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
module circular_linked_queue_manager
   import clqm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata: func [1:0], queue_id [4:2], elem_id [10:5], zero [15:11]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: status [1:0], elem_out [7:2], count [14:8], zero [15]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Request fields as they arrive.
   func_type  req_func;
   queue_type req_queue;
   elem_type  req_elem;

   assign req_func  = req_tdata[FUNC_W-1:0];
   assign req_queue = req_tdata[FUNC_W+QUEUE_W-1:FUNC_W];
   assign req_elem  = req_tdata[FUNC_W+QUEUE_W+ELEM_W-1:FUNC_W+QUEUE_W];

   // Decode stage holding one registered request.
   logic      s1_valid_ff;
   func_type  s1_func_ff;
   queue_type s1_queue_ff;
   elem_type  s1_elem_ff;

   // Response register.
   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   elem_type   rsp_elem_ff;
   count_type  rsp_count_ff;

   // Per-queue state and per-element linked flags.
   count_type count_ff  [NUM_QUEUES];
   elem_type  head_ff   [NUM_QUEUES];
   elem_type  tail_ff   [NUM_QUEUES];
   logic      linked_ff [POOL_SIZE];

   logic req_fire;
   logic s1_fire;
   logic rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   // Memory write ports driven by the decode stage.
   logic      next_wr_en;
   elem_type  next_wr_addr;
   elem_type  next_wr_data;
   logic      prev_wr_en;
   elem_type  prev_wr_addr;
   elem_type  prev_wr_data;
   logic      owner_wr_en;
   queue_type owner_wr_data;

   elem_type  next_rd;
   elem_type  prev_rd;
   queue_type owner_rd;

   // Successor of each element that is not the tail of its queue. The
   // tail's successor is the queue's head register.
   clqm_ram #(.WIDTH(ELEM_W), .DEPTH(POOL_SIZE)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_elem),
      .rd_data (next_rd)
   );

   // Predecessor of each element that is not the head of its queue. The
   // head's predecessor is the queue's tail register.
   clqm_ram #(.WIDTH(ELEM_W), .DEPTH(POOL_SIZE)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_elem),
      .rd_data (prev_rd)
   );

   // Queue that holds each linked element.
   clqm_ram #(.WIDTH(QUEUE_W), .DEPTH(POOL_SIZE)) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_wr_en),
      .wr_addr (s1_elem_ff),
      .wr_data (owner_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_elem),
      .rd_data (owner_rd)
   );

   // The memories return the old contents when the request behind reads an
   // entry written by the request ahead in the same cycle. The last write of
   // each memory is kept here and forwarded over the read data.
   logic      byp_next_en_ff;
   elem_type  byp_next_addr_ff;
   elem_type  byp_next_data_ff;
   logic      byp_prev_en_ff;
   elem_type  byp_prev_addr_ff;
   elem_type  byp_prev_data_ff;
   logic      byp_owner_en_ff;
   elem_type  byp_owner_addr_ff;
   queue_type byp_owner_data_ff;

   elem_type  cur_next;
   elem_type  cur_prev;
   queue_type cur_owner;

   always_comb begin
      cur_next  = next_rd;
      cur_prev  = prev_rd;
      cur_owner = owner_rd;
      if (byp_next_en_ff && (byp_next_addr_ff == s1_elem_ff)) begin
         cur_next = byp_next_data_ff;
      end
      if (byp_prev_en_ff && (byp_prev_addr_ff == s1_elem_ff)) begin
         cur_prev = byp_prev_data_ff;
      end
      if (byp_owner_en_ff && (byp_owner_addr_ff == s1_elem_ff)) begin
         cur_owner = byp_owner_data_ff;
      end
   end

   // Decode stage: one pass through the operation.
   count_type  cur_count;
   elem_type   cur_head;
   elem_type   cur_tail;
   logic       cur_linked;
   elem_type   succ;
   elem_type   pred;

   count_type  count_in;
   elem_type   head_in;
   elem_type   tail_in;
   logic       linked_in;
   logic       state_wr;
   status_type status_in;
   elem_type   elem_out_in;

   assign cur_count  = count_ff[s1_queue_ff];
   assign cur_head   = head_ff[s1_queue_ff];
   assign cur_tail   = tail_ff[s1_queue_ff];
   assign cur_linked = linked_ff[s1_elem_ff];

   // Ring neighbors of the element, with the ends closed through the
   // head and tail registers.
   assign succ = (s1_elem_ff == cur_tail) ? cur_head : cur_next;
   assign pred = (s1_elem_ff == cur_head) ? cur_tail : cur_prev;

   always_comb begin
      count_in      = cur_count;
      head_in       = cur_head;
      tail_in       = cur_tail;
      linked_in     = cur_linked;
      state_wr      = 1'b0;
      status_in     = STATUS_OK;
      elem_out_in   = '0;
      next_wr_en    = 1'b0;
      next_wr_addr  = pred;
      next_wr_data  = succ;
      prev_wr_en    = 1'b0;
      prev_wr_addr  = succ;
      prev_wr_data  = pred;
      owner_wr_en   = 1'b0;
      owner_wr_data = s1_queue_ff;

      case (s1_func_ff)
         FUNC_APPEND: begin
            if (cur_linked) begin
               status_in = STATUS_LINKED;
            end else begin
               state_wr    = 1'b1;
               linked_in   = 1'b1;
               count_in    = cur_count + COUNT_W'(1);
               owner_wr_en = 1'b1;
               tail_in     = s1_elem_ff;
               if (cur_count == '0) begin
                  // An empty queue becomes a self-loop.
                  head_in = s1_elem_ff;
               end else begin
                  // The old tail now points on to the new element.
                  next_wr_en   = 1'b1;
                  next_wr_addr = cur_tail;
                  next_wr_data = s1_elem_ff;
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = s1_elem_ff;
                  prev_wr_data = cur_tail;
               end
            end
         end
         FUNC_REMOVE: begin
            if (cur_count == '0) begin
               status_in = STATUS_EMPTY;
            end else if (!cur_linked || (cur_owner != s1_queue_ff)) begin
               status_in = STATUS_ABSENT;
            end else begin
               state_wr    = 1'b1;
               linked_in   = 1'b0;
               count_in    = cur_count - COUNT_W'(1);
               elem_out_in = s1_elem_ff;
               if (cur_count != COUNT_W'(1)) begin
                  // Splice the neighbors together and move the ends.
                  next_wr_en = 1'b1;
                  prev_wr_en = 1'b1;
                  if (s1_elem_ff == cur_head) begin
                     head_in = succ;
                  end
                  if (s1_elem_ff == cur_tail) begin
                     tail_in = pred;
                  end
               end
            end
         end
         default: begin
            // Size report leaves the state alone.
         end
      endcase

      if (!s1_fire) begin
         next_wr_en  = 1'b0;
         prev_wr_en  = 1'b0;
         owner_wr_en = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         byp_next_en_ff  <= 1'b0;
         byp_prev_en_ff  <= 1'b0;
         byp_owner_en_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
         end
         for (int i = 0; i < POOL_SIZE; i++) begin
            linked_ff[i] <= 1'b0;
         end
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            byp_next_en_ff  <= next_wr_en;
            byp_prev_en_ff  <= prev_wr_en;
            byp_owner_en_ff <= owner_wr_en;
            if (state_wr) begin
               count_ff[s1_queue_ff] <= count_in;
               linked_ff[s1_elem_ff] <= linked_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff  <= req_func;
         s1_queue_ff <= req_queue;
         s1_elem_ff  <= req_elem;
      end
      if (s1_fire) begin
         rsp_status_ff     <= status_in;
         rsp_elem_ff       <= elem_out_in;
         rsp_count_ff      <= count_in;
         byp_next_addr_ff  <= next_wr_addr;
         byp_next_data_ff  <= next_wr_data;
         byp_prev_addr_ff  <= prev_wr_addr;
         byp_prev_data_ff  <= prev_wr_data;
         byp_owner_addr_ff <= s1_elem_ff;
         byp_owner_data_ff <= owner_wr_data;
         if (state_wr) begin
            head_ff[s1_queue_ff] <= head_in;
            tail_ff[s1_queue_ff] <= tail_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - STATUS_W - ELEM_W - COUNT_W)'(0),
                        rsp_count_ff, rsp_elem_ff, rsp_status_ff};

endmodule
